/* design/mclp_pkg.sv */
// Shared types, character codes and decode helpers for the motor command line parser.
package mclp_pkg;

  localparam int unsigned LineStore = 6;

  typedef enum logic [1:0] {
    KIND_SIMPLE   = 2'd0,
    KIND_JOYSTICK = 2'd1,
    KIND_BAD      = 2'd2
  } kind_e;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChVtab    = 8'h0B;
  localparam logic [7:0] ChFf      = 8'h0C;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChF       = 8'h66;
  localparam logic [7:0] ChB       = 8'h62;
  localparam logic [7:0] ChR       = 8'h72;
  localparam logic [7:0] ChL       = 8'h6C;
  localparam logic [7:0] ChW       = 8'h77;
  localparam logic [7:0] ChS       = 8'h73;
  localparam logic [7:0] ChA       = 8'h61;
  localparam logic [7:0] ChD       = 8'h64;
  localparam logic [7:0] ChQ       = 8'h71;

  // Line summary handed from the collector to the decoder
  typedef struct packed {
    logic [LineStore-1:0][7:0] chars;
    logic                      len_one;
    logic                      len_six;
  } line_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChVtab) || (c == ChFf) || (c == ChCr);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // Two-character strtol: an optional blank or sign followed by one digit, or up to two digits
  function automatic logic signed [7:0] read_pair(input logic [7:0] c0, input logic [7:0] c1);
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] v1;
    logic [7:0] res;
    d0  = c0 - ChZero;
    d1  = c1 - ChZero;
    v1  = is_digit(c1) ? d1 : 8'd0;
    res = 8'd0;
    if (is_blank(c0)) begin
      res = v1;
    end else if (c0 == ChPlus) begin
      res = v1;
    end else if (c0 == ChMinus) begin
      res = 8'd0 - v1;
    end else if (is_digit(c0)) begin
      res = is_digit(c1) ? ((d0 << 3) + (d0 << 1) + d1) : d0;
    end
    return $signed(res);
  endfunction

endpackage

/* design/mclp_line_buf.sv */
// Line collector: stores the first characters of a line and tracks its length.
module mclp_line_buf #(
  parameter int unsigned LINE_CAPACITY = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output mclp_pkg::line_t      line_o
);
  import mclp_pkg::*;

  localparam int unsigned LenW = $clog2(LINE_CAPACITY);
  localparam logic [LenW-1:0] LenMax = LenW'(LINE_CAPACITY - 1);

  logic [LineStore-1:0][7:0] chars_q;
  logic [LenW-1:0]           len_q, len_d;
  logic                      zero_q, zero_d;
  logic                      store;

  always_comb begin
    len_d  = len_q;
    zero_d = zero_q;
    store  = 1'b0;
    if (step_i) begin
      if (byte_i == ChNewline) begin
        len_d  = '0;
        zero_d = 1'b0;
      end else if (!zero_q && (len_q < LenMax)) begin
        if (byte_i == ChNul) begin
          zero_d = 1'b1;
        end else begin
          store = 1'b1;
          len_d = len_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      zero_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      zero_q <= zero_d;
    end
  end

  // character store has no reset; only positions below the length are decoded
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LineStore; i++) begin
      if (store && (len_q == LenW'(i))) begin
        chars_q[i] <= byte_i;
      end
    end
  end

  assign line_o.chars   = chars_q;
  assign line_o.len_one = (len_q == LenW'(1));
  assign line_o.len_six = (len_q == LenW'(LineStore));

endmodule

/* design/mclp_decode.sv */
// Line decoder: turns a finished line into a command kind and new held speeds.
module mclp_decode (
  input  mclp_pkg::line_t     line_i,
  input  logic [6:0]          speed_i,
  input  logic signed [7:0]   throttle_i,
  input  logic signed [7:0]   turn_i,
  output mclp_pkg::kind_e     kind_o,
  output logic signed [7:0]   throttle_o,
  output logic signed [7:0]   turn_o
);
  import mclp_pkg::*;

  logic signed [7:0] sp_pos, sp_neg, t_val, r_val;
  logic              joy_ok;

  assign sp_pos = $signed({1'b0, speed_i});
  assign sp_neg = 8'sd0 - sp_pos;
  assign t_val  = read_pair(line_i.chars[1], line_i.chars[2]);
  assign r_val  = read_pair(line_i.chars[4], line_i.chars[5]);
  assign joy_ok = line_i.len_six &&
                  ((line_i.chars[0] == ChF) || (line_i.chars[0] == ChB)) &&
                  ((line_i.chars[3] == ChR) || (line_i.chars[3] == ChL));

  always_comb begin
    kind_o     = KIND_BAD;
    throttle_o = throttle_i;
    turn_o     = turn_i;
    if (line_i.len_one) begin
      kind_o = KIND_SIMPLE;
      case (line_i.chars[0])
        ChW: begin
          throttle_o = sp_pos;
          turn_o     = 8'sd0;
        end
        ChS: begin
          throttle_o = sp_neg;
          turn_o     = 8'sd0;
        end
        ChA: begin
          throttle_o = 8'sd0;
          turn_o     = sp_neg;
        end
        ChD: begin
          throttle_o = 8'sd0;
          turn_o     = sp_pos;
        end
        ChQ: begin
          throttle_o = 8'sd0;
          turn_o     = 8'sd0;
        end
        default: begin
          kind_o = KIND_BAD;
        end
      endcase
    end else if (joy_ok) begin
      kind_o     = KIND_JOYSTICK;
      throttle_o = (line_i.chars[0] == ChF) ? t_val : (8'sd0 - t_val);
      turn_o     = (line_i.chars[3] == ChR) ? r_val : (8'sd0 - r_val);
    end
  end

endmodule

/* design/motor_command_line_parser_top.sv */
// Top level of the motor command line parser: input stage, line state, result register.
//
//  channel     | dir | handshake                    | payload
//  ------------+-----+------------------------------+-------------------------------
//  s_axis      | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] rx_byte
//  m_axis      | out | m_axis_tvalid/m_axis_tready  | tdata kind, throttle, turn
//  cfg         | in  | cfg_valid_i/cfg_ready_o      | cfg_data_i drive speed magnitude
//
//  One byte per cycle sustained. A byte is held in the input register and is
//  folded into the line state on leaving it; a newline writes its result to the
//  output register as it leaves the input register, so a newline passes the input
//  register and then the output register before its result transaction can complete.
//  Only a newline waiting behind an unread result stalls the input; other bytes
//  keep flowing. Reset clears the line length, zero flag, held speeds and all
//  valid flags, and sets the drive speed to 40; no clearing pass.
module motor_command_line_parser_top #(
  parameter int unsigned LINE_CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] command_kind, [9:2] throttle, [17:10] turn, zeros
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);
  import mclp_pkg::*;

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_nl;
  logic              advance;
  logic [6:0]        speed_q;
  logic signed [7:0] thr_q, trn_q, thr_new, trn_new;
  kind_e             kind_new;
  line_t             line;
  logic              out_valid_q;
  logic [17:0]       out_data_q;

  assign in_nl         = (in_byte_q == ChNewline);
  assign advance       = in_valid_q && (!in_nl || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  mclp_line_buf #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_line (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .byte_i(in_byte_q),
    .line_o(line)
  );

  mclp_decode u_decode (
    .line_i    (line),
    .speed_i   (speed_q),
    .throttle_i(thr_q),
    .turn_i    (trn_q),
    .kind_o    (kind_new),
    .throttle_o(thr_new),
    .turn_o    (trn_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      speed_q     <= 7'd40;
      thr_q       <= 8'sd0;
      trn_q       <= 8'sd0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (cfg_valid_i) begin
        speed_q <= cfg_data_i;
      end
      if (advance && in_nl) begin
        out_valid_q <= 1'b1;
        thr_q       <= thr_new;
        trn_q       <= trn_new;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && in_nl) begin
      out_data_q <= {trn_new, thr_new, kind_new};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};

endmodule
